// ===== sv/calendar_date_counter_top_defines.svh =====
// Assertion macros used by the port checker of the date counter.
// Depends on nothing; included by the port checker.
`ifndef CALENDAR_DATE_COUNTER_TOP_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar date counter check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar date counter check failed");

`endif

// ===== sv/caldate_pkg.sv =====
// Types and constants shared by the calendar date counter modules.
// Depends on nothing.
`timescale 1ns / 1ps

package caldate_pkg;

  localparam logic [11:0] YEAR_LOW   = 12'd1900;
  localparam logic [11:0] YEAR_HIGH  = 12'd2100;
  localparam logic [11:0] YEAR_RESET = 12'd2021;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_APR  = 4'd4;
  localparam logic [3:0]  MONTH_JUN  = 4'd6;
  localparam logic [3:0]  MONTH_SEP  = 4'd9;
  localparam logic [3:0]  MONTH_NOV  = 4'd11;
  localparam logic        KIND_SET   = 1'b0;
  localparam logic        KIND_ADV   = 1'b1;

  typedef struct packed {
    logic load_set;
    logic load_adv;
    logic step;
    logic publish;
  } caldate_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic ovf;
  } caldate_sts_t;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MONTH_FEB: begin
        len = leap ? 5'd29 : 5'd28;
      end
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

// ===== sv/caldate_ctrl.sv =====
// Controller of the calendar date counter: accepts items, sequences the day steps
// and hands results to the output register. Depends on caldate_pkg.
`timescale 1ns / 1ps

module caldate_ctrl
  import caldate_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_kind,
  output logic         in_tready,
  input  logic         out_tready,
  output logic         out_tvalid,
  output caldate_cmd_t cmd,
  input  caldate_sts_t sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic done;
  logic out_free;

  assign done     = sts.cnt_zero || sts.ovf;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_set = (in_kind == KIND_SET);
          cmd.load_adv = (in_kind == KIND_ADV);
          state_nxt    = S_RUN;
        end
      end
      S_RUN: begin
        if (!done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/caldate_dp.sv =====
// Datapath of the calendar date counter: date registers, day stepping, set
// validation, leap tracking and the result register. Depends on caldate_pkg.
`timescale 1ns / 1ps

module caldate_dp
  import caldate_pkg::*;
#(
  parameter int YEAR_WIDTH  = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  caldate_cmd_t          cmd,
  output caldate_sts_t          sts,
  input  logic [5:0]            day_in,
  input  logic [3:0]            month_in,
  input  logic [11:0]           year_in,
  input  logic [15:0]           advance_days,
  output logic [4:0]            day_out,
  output logic [3:0]            month_out,
  output logic [YEAR_WIDTH-1:0] year_out,
  output logic                  leap_year,
  output logic                  overflow
);

  localparam int CNT_EXT = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};

  logic [4:0]             day_r, day_nxt;
  logic [3:0]             month_r, month_nxt;
  logic [YEAR_WIDTH-1:0]  year_r, year_nxt;
  logic [6:0]             mod100_r, mod100_nxt;
  logic [8:0]             mod400_r, mod400_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   leap_cur;
  logic [4:0]             len_cur;

  logic [3:0]             set_month;
  logic [11:0]            set_year;
  logic                   set_leap;
  logic [4:0]             set_len;
  logic [4:0]             set_day;
  logic [7:0]             set_off;
  logic [6:0]             set_mod100;
  logic [8:0]             set_mod400;
  logic [CNT_EXT-1:0]     adv_ext;

  assign leap_cur = (year_r[1:0] == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));
  assign len_cur  = days_in(month_r, leap_cur);

  assign set_month = ((month_in == 4'd0) || (month_in > MONTH_LAST)) ? 4'd1 : month_in;
  assign set_year  = ((year_in < YEAR_LOW) || (year_in > YEAR_HIGH)) ? YEAR_RESET : year_in;
  assign set_leap  = (set_year[1:0] == 2'd0) && (set_year != YEAR_LOW) &&
                     (set_year != YEAR_HIGH);
  assign set_len   = days_in(set_month, set_leap);
  assign set_day   = ((day_in == 6'd0) || (day_in > {1'b0, set_len})) ? 5'd1 : day_in[4:0];
  assign set_off   = 8'(set_year - YEAR_LOW);

  always_comb begin
    if (set_off >= 8'd200) begin
      set_mod100 = 7'(set_off - 8'd200);
    end else if (set_off >= 8'd100) begin
      set_mod100 = 7'(set_off - 8'd100);
    end else begin
      set_mod100 = set_off[6:0];
    end
    if (set_off >= 8'd100) begin
      set_mod400 = 9'({1'b0, set_off} - 9'd100);
    end else begin
      set_mod400 = {1'b0, set_off} + 9'd300;
    end
  end

  assign adv_ext = CNT_EXT'(advance_days);

  always_comb begin
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    if (cmd.load_set) begin
      day_nxt    = set_day;
      month_nxt  = set_month;
      year_nxt   = YEAR_WIDTH'(set_year);
      mod100_nxt = set_mod100;
      mod400_nxt = set_mod400;
      cnt_nxt    = '0;
      ovf_nxt    = 1'b0;
    end else if (cmd.load_adv) begin
      cnt_nxt = adv_ext[COUNT_WIDTH-1:0];
      ovf_nxt = 1'b0;
    end else if (cmd.step) begin
      if (day_r < len_cur) begin
        day_nxt = day_r + 5'd1;
        cnt_nxt = cnt_r - COUNT_WIDTH'(1);
      end else if (month_r < MONTH_LAST) begin
        month_nxt = month_r + 4'd1;
        day_nxt   = 5'd1;
        cnt_nxt   = cnt_r - COUNT_WIDTH'(1);
      end else if (year_r != YEAR_MAX) begin
        year_nxt   = year_r + YEAR_WIDTH'(1);
        month_nxt  = 4'd1;
        day_nxt    = 5'd1;
        mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
        mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
        cnt_nxt    = cnt_r - COUNT_WIDTH'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.ovf      = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r    <= 5'd1;
      month_r  <= 4'd1;
      year_r   <= YEAR_WIDTH'(YEAR_RESET);
      mod100_r <= 7'd21;
      mod400_r <= 9'd21;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      mod100_r <= mod100_nxt;
      mod400_r <= mod400_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      day_out   <= day_r;
      month_out <= month_r;
      year_out  <= year_r;
      leap_year <= leap_cur;
      overflow  <= ovf_r;
    end
  end

endmodule

// ===== sv/calendar_date_counter_top.sv =====
// Calendar date counter top level: joins the controller and the datapath.
// Sequence: a set loads the checked date from the transfer; an advance of N days steps
// the date one day per cycle in the day stepping loop of the datapath until N days are
// done or the year overflows. Each result is published once the output register is free.
// Flow: one item is processed at a time; the next transfer is taken while a result waits.
// Reset: synchronous, active low; the date becomes January 1, 2021 and no result is held.
`timescale 1ns / 1ps

module calendar_date_counter_top
  import caldate_pkg::*;
#(
  parameter int YEAR_WIDTH  = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // day_in[5:0], month_in[9:6], year_in[21:10], advance_days[37:22], zero fill.
  input  logic [39:0]                         in_tdata,
  // kind.
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // day_out, month_out, year_out, leap_year, overflow, zero fill.
  output logic [((YEAR_WIDTH + 18) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_W = ((YEAR_WIDTH + 18) / 8) * 8;

  caldate_cmd_t          cmd;
  caldate_sts_t          sts;
  logic [4:0]            day_out;
  logic [3:0]            month_out;
  logic [YEAR_WIDTH-1:0] year_out;
  logic                  leap_year;
  logic                  overflow;

  caldate_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  caldate_dp #(
    .YEAR_WIDTH  (YEAR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .day_in       (in_tdata[5:0]),
    .month_in     (in_tdata[9:6]),
    .year_in      (in_tdata[21:10]),
    .advance_days (in_tdata[37:22]),
    .day_out      (day_out),
    .month_out    (month_out),
    .year_out     (year_out),
    .leap_year    (leap_year),
    .overflow     (overflow)
  );

  assign out_tdata = OUT_W'({overflow, leap_year, year_out, month_out, day_out});

endmodule

// ===== sv/caldate_checker.sv =====
// Port checker for the calendar date counter, bound to the top level.
// Depends on calendar_date_counter_top_defines.svh.
`timescale 1ns / 1ps
`include "calendar_date_counter_top_defines.svh"

module caldate_checker #(
  parameter int YEAR_WIDTH = 12
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((YEAR_WIDTH + 18) / 8) * 8 - 1:0] out_tdata
);

  localparam int OVF_BIT = YEAR_WIDTH + 10;

  logic [4:0] day_o;
  logic [3:0] month_o;
  logic       ovf_o;

  assign day_o   = out_tdata[4:0];
  assign month_o = out_tdata[8:5];
  assign ovf_o   = out_tdata[OVF_BIT];

  `CD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))
  `CD_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `CD_ASSERT_SAME(a_date_range, clk, rst_n, out_tvalid,
    (day_o != 5'd0) && (month_o != 4'd0) && (month_o <= 4'd12))
  `CD_ASSERT_SAME(a_ovf_year_end, clk, rst_n, out_tvalid && ovf_o,
    (day_o == 5'd31) && (month_o == 4'd12))

endmodule

bind calendar_date_counter_top caldate_checker #(
  .YEAR_WIDTH (YEAR_WIDTH)
) u_caldate_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
